@@ design/pidc_pkg.sv @@
// Shared types, constants and saturation helpers for the PID controller.
// Used by the serial arithmetic unit and by the top level; no dependencies.
package pidc_pkg;

    localparam int VW = 32;
    localparam int FB = 16;

    localparam logic [1:0] OP_STEP  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_KP     = 3'd1;
    localparam logic [2:0] REG_KI     = 3'd2;
    localparam logic [2:0] REG_KD     = 3'd3;
    localparam logic [2:0] REG_SP     = 3'd4;
    localparam logic [2:0] REG_OUTLIM = 3'd5;
    localparam logic [2:0] REG_LIMIT  = 3'd6;
    localparam logic [2:0] REG_AUX    = 3'd7;

    localparam logic [4:0]  MODE_RST = 5'd3;
    localparam logic [63:0] OUTLIM_RST = 64'd28147497671065600;
    localparam logic [63:0] LIMIT_RST  = 64'd28147497671720960;
    localparam logic [63:0] AUX_RST    = 64'd3602880251669033779;
    localparam logic [16:0] ALPHA_ONE  = 17'd65536;

    typedef struct packed {
        logic        start;
        logic        is_div;
        logic        sh8;
        logic        neg;
        logic [32:0] a;
        logic [32:0] b;
    } t_arith_req;

    typedef struct packed {
        logic               done;
        logic signed [31:0] value;
    } t_arith_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        logic signed [31:0] r;
        if (x > 35'sh07FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -35'sh080000000) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [34:0] ext(input logic signed [31:0] x);
        return {{3{x[31]}}, x};
    endfunction

    function automatic logic signed [34:0] ext33(input logic signed [32:0] x);
        return {{2{x[32]}}, x};
    endfunction

    function automatic logic [32:0] smag(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : v;
    endfunction

endpackage

@@ design/pidc_serial_unit.sv @@
// Bit-serial multiplier and restoring divider on sign and magnitude operands.
// Depends on pidc_pkg for the request and response structs.
module pidc_serial_unit import pidc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [65:0] r_acc;
    logic [32:0] r_den;
    logic        r_div;
    logic        r_sh8;
    logic        r_neg;
    logic [31:0] r_rem;

    logic [33:0] msum;
    logic [32:0] dsh;
    logic [33:0] ddif;
    logic [65:0] mg;
    logic        big;

    assign msum = {1'b0, r_acc[65:33]} + (r_acc[0] ? {1'b0, r_den} : 34'd0);
    assign dsh  = {r_rem, r_acc[48]};
    assign ddif = {1'b0, dsh} - {2'b0, r_den[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 6'd0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
            r_div  <= i_req.is_div;
            r_sh8  <= i_req.sh8;
            r_neg  <= i_req.neg;
            r_rem  <= 32'd0;
            if (i_req.is_div) begin
                r_acc <= {17'd0, i_req.a, 16'd0};
                r_den <= i_req.b;
                r_cnt <= 6'd49;
            end else begin
                r_acc <= {33'd0, i_req.b};
                r_den <= i_req.a;
                r_cnt <= 6'd33;
            end
        end else if (r_busy) begin
            if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_div) begin
                    r_rem <= ddif[33] ? dsh[31:0] : ddif[31:0];
                    r_acc <= {r_acc[65:49], r_acc[47:0], ~ddif[33]};
                end else begin
                    r_acc <= {msum, r_acc[32:1]};
                end
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_div) begin
            mg = {17'd0, r_acc[48:0]};
        end else if (r_sh8) begin
            mg = {8'd0, r_acc[65:8]};
        end else begin
            mg = {16'd0, r_acc[65:16]};
        end
        big = |mg[65:32];
        o_rsp.done = r_busy && (r_cnt == 6'd0);
        if (r_div && (r_den[31:0] == 32'd0)) begin
            o_rsp.value = 32'sd0;
        end else if (r_neg) begin
            o_rsp.value = (big || (mg[31] && |mg[30:0])) ? 32'sh80000000 : -mg[31:0];
        end else begin
            o_rsp.value = (big || mg[31]) ? 32'sh7FFFFFFF : mg[31:0];
        end
    end

endmodule

@@ design/pid_controller_with_ramp_and_antiwindup_unit.sv @@
// PID controller with setpoint ramp, safety cut and anti-windup.
// Depends on pidc_pkg and instantiates pidc_serial_unit.
//
// Input channel: opcode, sample and step time, taken when i_in_valid is high
// and o_in_stall is low. Output channel: drive and emergency flag, taken when
// o_out_valid is high and i_out_stall is low. Configuration writes use
// i_cfg_valid and o_cfg_ready with a register index and 64-bit data; the
// ready is high only while the block is idle, and the input is stalled while
// a write is offered.
// A control step runs its products and quotients one after another through a
// single bit-serial unit. A step cut by the safety check ends before the gain
// products, and the clear and reset opcodes do not use the serial unit.
// The result sits in an output register; the next transaction is accepted
// while it waits, and a finished result is held until the receiver takes it.
// Reset restores the register defaults and clears all controller history.
module pid_controller_with_ramp_and_antiwindup_unit import pidc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_sample,
    input  logic [31:0]        i_step_time,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_drive,
    output logic               o_emergency_stop,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);

    typedef enum logic [16:0] {
        S_IDLE = 17'b00000000000000001,
        S_RAMP = 17'b00000000000000010,
        S_RMUL = 17'b00000000000000100,
        S_RUPD = 17'b00000000000001000,
        S_CHK  = 17'b00000000000010000,
        S_PMUL = 17'b00000000000100000,
        S_SMUL = 17'b00000000001000000,
        S_INT  = 17'b00000000010000000,
        S_IMUL = 17'b00000000100000000,
        S_DDIV = 17'b00000001000000000,
        S_FM1  = 17'b00000010000000000,
        S_FM2  = 17'b00000100000000000,
        S_FS   = 17'b00001000000000000,
        S_DMUL = 17'b00010000000000000,
        S_FF   = 17'b00100000000000000,
        S_SUM  = 17'b01000000000000000,
        S_DONE = 17'b10000000000000000
    } t_state;

    t_state r_state;

    logic [4:0]         r_mode;
    logic [31:0]        r_kp, r_ki, r_kd;
    logic signed [31:0] r_sp;
    logic [63:0]        r_olim, r_lim, r_aux;

    logic signed [32:0] r_isum;
    logic signed [31:0] r_pe, r_pd, r_ps, r_fs, r_rt;
    logic               r_emg;

    logic signed [31:0] r_s;
    logic [31:0]        r_dt;
    logic signed [31:0] r_err, r_pt, r_it, r_dtm, r_ff, r_step, r_t1, r_t2, r_res;
    logic               r_wait;
    logic               r_ov;

    t_arith_req req;
    t_arith_rsp rsp;

    logic signed [31:0] omin, omax, margin, imax;
    logic [15:0]        alpha, rate, ffg, amp;
    logic signed [31:0] err_c;
    logic signed [34:0] diff, absd;
    logic signed [32:0] num;
    logic signed [34:0] iclamp;
    logic signed [31:0] itmp;
    logic signed [31:0] dsum;
    logic signed [31:0] dclamp;
    logic signed [32:0] bop;

    assign omin   = r_olim[31:0];
    assign omax   = r_olim[63:32];
    assign margin = r_lim[31:0];
    assign imax   = r_lim[63:32];
    assign alpha  = r_aux[15:0];
    assign rate   = r_aux[31:16];
    assign ffg    = r_aux[47:32];
    assign amp    = r_aux[63:48];

    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

    assign err_c = sat32(ext(r_rt) - ext(r_s));
    assign diff  = ext(r_sp) - ext(r_rt);
    assign absd  = diff[34] ? -diff : diff;
    assign num   = r_mode[0] ? {itmp[31], itmp} : 33'(ext(r_err) - ext(r_pe));
    assign dsum  = sat32(ext(r_pt) + ext(r_it) + ext(r_dtm) + ext(r_ff));
    assign bop   = r_mode[0] ? {r_fs[31], r_fs} : {r_t1[31], r_t1};

    always_comb begin
        itmp = sat32(ext(r_ps) - ext(r_s));
        if (r_state == S_INT) begin
            itmp = sat32(ext33(r_isum) + ext(r_step));
        end
        iclamp = ext(itmp);
        if (r_mode[1]) begin
            if (iclamp < -ext(imax)) begin
                iclamp = -ext(imax);
            end else if (iclamp > ext(imax)) begin
                iclamp = ext(imax);
            end
            if (((r_pd >= omax) && (r_err > 32'sd0)) ||
                ((r_pd <= omin) && (r_err < 32'sd0))) begin
                iclamp = ext(sat32(iclamp - ext(r_step)));
            end
        end
        dclamp = dsum;
        if (dsum < omin) begin
            dclamp = omin;
        end else if (dsum > omax) begin
            dclamp = omax;
        end
    end

    always_comb begin
        req.start  = !r_wait;
        req.is_div = 1'b0;
        req.sh8    = 1'b0;
        req.neg    = 1'b0;
        req.a      = 33'd0;
        req.b      = 33'd0;
        case (r_state)
            S_RMUL: begin
                req.sh8 = 1'b1;
                req.a   = {17'd0, rate};
                req.b   = {1'b0, r_dt};
            end
            S_PMUL: begin
                req.neg = r_err[31];
                req.a   = {1'b0, r_kp};
                req.b   = smag({r_err[31], r_err});
            end
            S_SMUL: begin
                req.neg = r_err[31];
                req.a   = smag({r_err[31], r_err});
                req.b   = {1'b0, r_dt};
            end
            S_IMUL: begin
                req.neg = r_isum[32];
                req.a   = {1'b0, r_ki};
                req.b   = smag(r_isum);
            end
            S_DDIV: begin
                req.is_div = 1'b1;
                req.neg    = num[32];
                req.a      = smag(num);
                req.b      = {1'b0, r_dt};
            end
            S_FM1: begin
                req.neg = r_t1[31];
                req.a   = smag({r_t1[31], r_t1});
                req.b   = {17'd0, alpha};
            end
            S_FM2: begin
                req.neg = r_fs[31];
                req.a   = smag({r_fs[31], r_fs});
                req.b   = {16'd0, 17'(ALPHA_ONE - {1'b0, alpha})};
            end
            S_DMUL: begin
                req.neg = bop[32];
                req.a   = {1'b0, r_kd};
                req.b   = smag(bop);
            end
            S_FF: begin
                req.start = !r_wait && r_mode[3];
                req.sh8   = 1'b1;
                req.a     = {17'd0, ffg};
                req.neg   = r_rt[31];
                req.b     = smag({r_rt[31], r_rt});
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

    pidc_serial_unit u_serial (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
            r_ov    <= 1'b0;
            r_mode  <= MODE_RST;
            r_kp    <= 32'd0;
            r_ki    <= 32'd0;
            r_kd    <= 32'd0;
            r_sp    <= 32'sd0;
            r_olim  <= OUTLIM_RST;
            r_lim   <= LIMIT_RST;
            r_aux   <= AUX_RST;
            r_isum  <= 33'sd0;
            r_pe    <= 32'sd0;
            r_pd    <= 32'sd0;
            r_ps    <= 32'sd0;
            r_fs    <= 32'sd0;
            r_rt    <= 32'sd0;
            r_emg   <= 1'b0;
        end else begin
            if (req.start) begin
                r_wait <= 1'b1;
            end
            if (rsp.done) begin
                r_wait <= 1'b0;
            end
            if (r_ov && !i_out_stall && (r_state != S_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !i_cfg_valid) begin
                        r_s     <= i_sample;
                        r_dt    <= i_step_time;
                        r_state <= S_DONE;
                        case (i_opcode)
                            OP_STEP: begin
                                r_state <= S_RAMP;
                            end
                            OP_CLEAR: begin
                                r_emg  <= 1'b0;
                                r_isum <= 33'sd0;
                                r_res  <= r_pd;
                            end
                            OP_RESET: begin
                                r_isum <= 33'sd0;
                                r_pe   <= 32'sd0;
                                r_pd   <= 32'sd0;
                                r_res  <= 32'sd0;
                            end
                            default: begin
                                r_res <= r_pd;
                            end
                        endcase
                    end
                end
                S_RAMP: begin
                    if (!r_mode[2]) begin
                        r_rt    <= r_sp;
                        r_state <= S_CHK;
                    end else if (r_dt != 32'd0) begin
                        r_state <= S_RMUL;
                    end else begin
                        r_state <= S_CHK;
                    end
                end
                S_RMUL: begin
                    if (rsp.done) begin
                        r_t1    <= rsp.value;
                        r_state <= S_RUPD;
                    end
                end
                S_RUPD: begin
                    if (absd <= ext(r_t1)) begin
                        r_rt <= r_sp;
                    end else if (diff > 35'sd0) begin
                        r_rt <= sat32(ext(r_rt) + ext(r_t1));
                    end else begin
                        r_rt <= sat32(ext(r_rt) - ext(r_t1));
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_err <= err_c;
                    if (ext(r_s) > ext(r_sp) + ext(margin)) begin
                        r_emg   <= 1'b1;
                        r_res   <= 32'sd0;
                        r_state <= S_DONE;
                    end else if (r_mode[4]) begin
                        if (err_c > 32'sd0) begin
                            r_res <= {8'd0, amp, 8'd0};
                            r_pd  <= {8'd0, amp, 8'd0};
                        end else begin
                            r_res <= 32'sd0;
                            r_pd  <= 32'sd0;
                        end
                        r_ps    <= r_s;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (rsp.done) begin
                        r_pt    <= rsp.value;
                        r_state <= S_SMUL;
                    end
                end
                S_SMUL: begin
                    if (rsp.done) begin
                        r_step  <= rsp.value;
                        r_state <= S_INT;
                    end
                end
                S_INT: begin
                    r_isum  <= iclamp[32:0];
                    r_state <= S_IMUL;
                end
                S_IMUL: begin
                    if (rsp.done) begin
                        r_it <= rsp.value;
                        if (r_dt != 32'd0) begin
                            r_state <= S_DDIV;
                        end else if (r_mode[0]) begin
                            r_state <= S_DMUL;
                        end else begin
                            r_dtm   <= 32'sd0;
                            r_state <= S_FF;
                        end
                    end
                end
                S_DDIV: begin
                    if (rsp.done) begin
                        r_t1    <= rsp.value;
                        r_state <= r_mode[0] ? S_FM1 : S_DMUL;
                    end
                end
                S_FM1: begin
                    if (rsp.done) begin
                        r_t2    <= rsp.value;
                        r_state <= S_FM2;
                    end
                end
                S_FM2: begin
                    if (rsp.done) begin
                        r_t1    <= rsp.value;
                        r_state <= S_FS;
                    end
                end
                S_FS: begin
                    r_fs    <= sat32(ext(r_t2) + ext(r_t1));
                    r_state <= S_DMUL;
                end
                S_DMUL: begin
                    if (rsp.done) begin
                        r_dtm   <= rsp.value;
                        r_state <= S_FF;
                    end
                end
                S_FF: begin
                    if (!r_mode[3]) begin
                        r_ff    <= 32'sd0;
                        r_state <= S_SUM;
                    end else if (rsp.done) begin
                        r_ff    <= rsp.value;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_res   <= dclamp;
                    r_pd    <= dclamp;
                    r_pe    <= r_err;
                    r_ps    <= r_s;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_ov             <= 1'b1;
                        o_drive          <= r_res;
                        o_emergency_stop <= r_emg;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_MODE:   r_mode <= i_cfg_data[4:0];
                    REG_KP:     r_kp   <= i_cfg_data[31:0];
                    REG_KI:     r_ki   <= i_cfg_data[31:0];
                    REG_KD:     r_kd   <= i_cfg_data[31:0];
                    REG_SP: begin
                        r_sp   <= i_cfg_data[31:0];
                        r_isum <= 33'sd0;
                        if (!r_mode[2]) begin
                            r_rt <= i_cfg_data[31:0];
                        end else if (r_rt == 32'sd0) begin
                            r_rt <= r_ps;
                        end
                    end
                    REG_OUTLIM: r_olim <= i_cfg_data;
                    REG_LIMIT:  r_lim  <= i_cfg_data;
                    REG_AUX:    r_aux  <= i_cfg_data;
                    default:    r_aux  <= r_aux;
                endcase
            end
        end
    end

endmodule

@@ design/pidc_checker.sv @@
// Port-level checks for the PID controller top level, with the bind that
// attaches them. Depends only on the top level's ports.
module pidc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_drive,
    input logic               o_emergency_stop
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("Output valid after reset.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("Input not stalled while a transaction is in work.");

    a_hold_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_drive)))
        else $error("Stalled drive changed.");

    a_hold_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_emergency_stop))
        else $error("Stalled emergency flag changed.");

endmodule

bind pid_controller_with_ramp_and_antiwindup_unit pidc_checker u_pidc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_drive          (o_drive),
    .o_emergency_stop (o_emergency_stop)
);

@@ bench/tb_pid_controller_with_ramp_and_antiwindup_unit.sv @@
// Self-checking testbench for the PID controller with ramp and anti-windup.
// Depends on pidc_pkg and pid_controller_with_ramp_and_antiwindup_unit.
// Predicts every drive value and flag, and checks each output transaction.
`timescale 1ns / 1ps

module tb_pid_controller_with_ramp_and_antiwindup_unit;
    import pidc_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_opcode;
    logic signed [31:0] i_sample;
    logic [31:0]        i_step_time;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_drive;
    logic               o_emergency_stop;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;

    pid_controller_with_ramp_and_antiwindup_unit dut (.*);

    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;
    localparam longint CAP  = 64'sd4611686018427387904;

    // Model state and register copies.
    logic [4:0]      m_mode;
    longint unsigned m_kp, m_ki, m_kd;
    longint          m_sp;
    logic [63:0]     m_outlim, m_limit, m_aux;
    longint          m_integ, m_perr, m_pdrv, m_psmp, m_fslope, m_rtgt;
    bit              m_emg;

    int  failures;
    bit  calm;
    int  idle_cycles;

    function automatic longint sat_v(longint x);
        return x > VMAX ? VMAX : (x < VMIN ? VMIN : x);
    endfunction

    function automatic longint word_s(logic [31:0] w);
        return longint'(signed'(w));
    endfunction

    function automatic longint unsigned mag(longint a);
        return a < 0 ? longint'(0) - a : a;
    endfunction

    function automatic longint mulq(longint a, longint b, int sh);
        logic [127:0] p;
        longint v;
        p = (128'(mag(a)) * 128'(mag(b))) >> sh;
        if (p > 128'(CAP)) p = 128'(CAP);
        v = longint'(p[63:0]);
        return sat_v(((a < 0) != (b < 0)) ? -v : v);
    endfunction

    function automatic longint divq(longint num, longint unsigned den);
        longint unsigned m, q, r;
        if (den == 0) return 0;
        m = mag(num);
        q = m / den;
        r = m % den;
        if (q >= CAP) q = CAP;
        for (int k = 0; k < FB; k++) begin
            if (q >= CAP / 2) begin
                q = CAP;
                break;
            end
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return sat_v(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    function automatic longint clamp_lh(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic void model_reset();
        m_mode = MODE_RST;
        m_kp = 0; m_ki = 0; m_kd = 0; m_sp = 0;
        m_outlim = OUTLIM_RST; m_limit = LIMIT_RST; m_aux = AUX_RST;
        m_integ = 0; m_perr = 0; m_pdrv = 0; m_psmp = 0; m_fslope = 0; m_rtgt = 0;
        m_emg = 0;
    endfunction

    function automatic void model_write(logic [2:0] idx, logic [63:0] d);
        case (idx)
            REG_MODE: m_mode = d[4:0];
            REG_KP: m_kp = d[31:0];
            REG_KI: m_ki = d[31:0];
            REG_KD: m_kd = d[31:0];
            REG_SP: begin
                m_sp = word_s(d[31:0]);
                if (!m_mode[2]) m_rtgt = m_sp;
                else if (m_rtgt == 0) m_rtgt = m_psmp;
                m_integ = 0;
            end
            REG_OUTLIM: m_outlim = d;
            REG_LIMIT: m_limit = d;
            default: m_aux = d;
        endcase
    endfunction

    function automatic longint control_step(longint s, longint unsigned dt);
        longint omin, omax, margin, imax, alpha, rate, ffg, amp;
        longint err, pt, it, dtm, ff, stp, drv, maxc, diff, raw;
        omin = word_s(m_outlim[31:0]);
        omax = word_s(m_outlim[63:32]);
        margin = word_s(m_limit[31:0]);
        imax = word_s(m_limit[63:32]);
        alpha = m_aux[15:0];
        rate = m_aux[31:16];
        ffg = m_aux[47:32];
        amp = m_aux[63:48];
        if (m_mode[2]) begin
            if (dt > 0) begin
                maxc = mulq(rate, longint'(dt), 8);
                diff = m_sp - m_rtgt;
                if (longint'(mag(diff)) <= maxc) m_rtgt = m_sp;
                else if (diff > 0) m_rtgt = sat_v(m_rtgt + maxc);
                else m_rtgt = sat_v(m_rtgt - maxc);
            end
        end else begin
            m_rtgt = m_sp;
        end
        if (s > m_sp + margin) begin
            m_emg = 1;
            return 0;
        end
        err = sat_v(m_rtgt - s);
        if (m_mode[4]) begin
            drv = err > 0 ? sat_v(amp << (FB - 8)) : 0;
            m_pdrv = drv;
            m_psmp = s;
            return drv;
        end
        pt = mulq(longint'(m_kp), err, FB);
        stp = mulq(err, longint'(dt), FB);
        m_integ = sat_v(m_integ + stp);
        if (m_mode[1]) begin
            m_integ = clamp_lh(m_integ, -imax, imax);
            if ((m_pdrv >= omax && err > 0) || (m_pdrv <= omin && err < 0))
                m_integ = sat_v(m_integ - stp);
        end
        it = mulq(longint'(m_ki), m_integ, FB);
        if (m_mode[0]) begin
            if (dt > 0) begin
                raw = divq(sat_v(m_psmp - s), dt);
                m_fslope = sat_v(mulq(raw, alpha, 16) +
                                 mulq(m_fslope, longint'(ALPHA_ONE) - alpha, 16));
            end
            dtm = mulq(longint'(m_kd), m_fslope, FB);
        end else begin
            dtm = dt > 0 ? mulq(longint'(m_kd), divq(err - m_perr, dt), FB) : 0;
        end
        ff = m_mode[3] ? mulq(ffg, m_rtgt, 8) : 0;
        drv = clamp_lh(sat_v(pt + it + dtm + ff), omin, omax);
        m_perr = err;
        m_pdrv = drv;
        m_psmp = s;
        return drv;
    endfunction

    typedef struct {
        logic [31:0] drive;
        logic        emg;
    } t_drive_result;

    class drive_scoreboard;
        t_drive_result pending[$];

        function void note_input(logic [1:0] op, logic [31:0] s, logic [31:0] dt);
            t_drive_result r;
            longint d;
            d = m_pdrv;
            case (op)
                OP_STEP: d = control_step(word_s(s), longint'(dt));
                OP_CLEAR: begin
                    m_emg = 0;
                    m_integ = 0;
                end
                OP_RESET: begin
                    m_integ = 0; m_perr = 0; m_pdrv = 0;
                    d = 0;
                end
                default: ;
            endcase
            r.drive = d[31:0];
            r.emg = m_emg;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] drv, logic emg);
            t_drive_result r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result drive %h flag %b", $time, drv, emg);
                failures++;
                return;
            end
            r = pending.pop_front();
            if (drv !== r.drive) begin
                $display("%0t: drive expected %h actual %h", $time, r.drive, drv);
                failures++;
            end
            if (emg !== r.emg) begin
                $display("%0t: emergency expected %b actual %b", $time, r.emg, emg);
                failures++;
            end
        endfunction
    endclass

    drive_scoreboard sb;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) sb.note_input(i_opcode, i_sample, i_step_time);
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_drive, o_emergency_stop);
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 7);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= 20000) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] d);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_write(idx, d);
        i_cfg_valid <= 0;
    endtask

    task automatic send_item(logic [1:0] op, logic [31:0] s, logic [31:0] dt);
        i_opcode <= op;
        i_sample <= s;
        i_step_time <= dt;
        i_in_valid <= 1;
        do @(posedge i_clk); while (o_in_stall);
        if (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_gain();
        case ($urandom_range(9))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    task automatic random_phase(int n);
        longint s, mrg;
        logic [1:0] op;
        logic [31:0] dt;
        mrg = word_s(m_limit[31:0]);
        for (int k = 0; k < n; k++) begin
            calm = (k >= n / 3 && k < n / 2);
            case ($urandom_range(19))
                0: op = OP_CLEAR;
                1: op = OP_RESET;
                2: op = OP_SPARE;
                default: op = OP_STEP;
            endcase
            case ($urandom_range(9))
                0: s = word_s($urandom);
                1: s = m_sp + mrg + $urandom_range(0, 4) - 2;
                default: s = m_sp + longint'($urandom_range(0, 32'h00C8_0000)) - 64'sh64_0000;
            endcase
            case ($urandom_range(9))
                0: dt = 0;
                1: dt = $urandom;
                default: dt = $urandom_range(1, 32'h0002_0000);
            endcase
            send_item(op, 32'(sat_v(s)), dt);
        end
        calm = 0;
    endtask

    initial begin
        logic [4:0] md;
        logic [31:0] lo, hi;
        sb = new();
        model_reset();
        failures = 0;
        calm = 0;
        i_rst_n <= 0;
        i_in_valid <= 0;
        i_opcode <= OP_STEP;
        i_sample <= 0;
        i_step_time <= 0;
        i_cfg_valid <= 0;
        i_cfg_index <= REG_MODE;
        i_cfg_data <= 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: defaults first, then a plain configuration and the corner items.
        send_item(OP_STEP, 32'h0005_0000, 32'h0001_0000);
        drain();
        write_reg(REG_MODE, 64'd3);
        write_reg(REG_KP, 64'h0001_0000);
        write_reg(REG_KI, 64'h0000_8000);
        write_reg(REG_KD, 64'h0000_4000);
        write_reg(REG_OUTLIM, {32'h0064_0000, 32'hFF9C_0000});
        write_reg(REG_LIMIT, {32'h0064_0000, 32'h000A_0000});
        write_reg(REG_AUX, AUX_RST);
        write_reg(REG_SP, 64'h0032_0000);
        send_item(OP_STEP, 32'h0000_0000, 32'h0001_0000);
        send_item(OP_STEP, 32'h0010_0000, 32'h0000_0000);
        send_item(OP_STEP, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(OP_STEP, 32'h7FFF_FFFF, 32'h0000_0001);
        send_item(OP_STEP, 32'h0020_0000, 32'h0000_8000);
        send_item(OP_CLEAR, 32'h0, 32'h0);
        send_item(OP_STEP, 32'h003C_0001, 32'h0001_0000);
        send_item(OP_STEP, 32'h003C_0000, 32'h0001_0000);
        send_item(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RESET, 32'h0, 32'h0);
        send_item(OP_STEP, 32'h0030_0000, 32'h7FFF_FFFF);
        drain();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: md = 5'd0;
                1: md = 5'd31;
                2: md = 5'd15;
                3: md = 5'd7;
                default: md = $urandom;
            endcase
            write_reg(REG_MODE, 64'(md));
            write_reg(REG_KP, 64'(rand_gain()));
            write_reg(REG_KI, 64'(rand_gain()));
            write_reg(REG_KD, 64'(rand_gain()));
            lo = p == 5 ? 32'h8000_0000 : 32'hFF00_0000 | $urandom_range(0, 32'hFFFF);
            hi = p == 5 ? 32'h7FFF_FFFF : $urandom_range(0, 32'h00FF_FFFF);
            if (p == 6) write_reg(REG_OUTLIM, {lo, hi});
            else write_reg(REG_OUTLIM, {hi, lo});
            write_reg(REG_LIMIT, p == 7 ? {$urandom, $urandom} :
                      {32'($urandom_range(0, 32'h00FF_FFFF)), 32'($urandom_range(0, 32'h0020_0000))});
            write_reg(REG_AUX, p == 4 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
            write_reg(REG_SP, 64'(32'(p == 3 ? $urandom :
                      $urandom_range(0, 32'h00C8_0000) - 32'h0064_0000)));
            random_phase(250);
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (failures == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
